@@ hw/rtl/fftk_pkg.sv @@
// ----------------------------------------------------------------------------
// fftk_pkg: shared types and constants of the fragmented-file top-K tracker
// Defines operation, result and state codes, the ranked entry type and the
// control word that the top level broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package fftk_pkg;

  localparam int unsigned DEFAULT_TOP_DEPTH = 32;

  localparam int unsigned TAG_W     = 16;
  localparam int unsigned FRAG_W    = 16;
  localparam int unsigned SIZE_W    = 48;
  localparam int unsigned FILES_W   = 20;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned MINSIZE_W = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [MINSIZE_W-1:0] DEFAULT_MIN_SIZE  = MINSIZE_W'(4096);
  localparam logic [FILES_W-1:0]   DEFAULT_MAX_FILES = FILES_W'(10000);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_FILE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FILES     = 1'b1;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ENTRY   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_COUNTED = 2'd0,
    STATUS_SMALL   = 2'd1,
    STATUS_LIMIT   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_ROTATE = 1'b1
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [FRAG_W-1:0] frag;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Broadcast to every cell: insert the new file, or rotate the ring by one.
  typedef struct packed {
    logic   ins;
    logic   rot;
    entry_t item;
  } cell_ctl_t;

endpackage

@@ hw/rtl/fftk_cell.sv @@
// ----------------------------------------------------------------------------
// fftk_cell: one rank of the sorted table
// Holds one entry. On insert it keeps its entry, takes the new file or takes
// its upper neighbour's entry; on rotate it takes its lower neighbour's entry.
// ----------------------------------------------------------------------------
module fftk_cell
  import fftk_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] count,
  input  logic             prev_keep,
  input  entry_t           prev_ent,
  input  entry_t           next_ent,
  output entry_t           ent,
  output logic             keep
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   occupied;

  assign occupied = count > CNT_W'(IDX);

  // An occupied entry that ranks at or above the new file stays in place,
  // which also keeps arrival order among ties.
  assign keep = occupied &&
                ((ent_r.frag > ctl.item.frag) ||
                 ((ent_r.frag == ctl.item.frag) && (ent_r.size >= ctl.item.size)));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.rot) begin
      ent_nxt = next_ent;
    end else if (ctl.ins) begin
      if (keep) begin
        ent_nxt = ent_r;
      end else if (prev_keep) begin
        ent_nxt = ctl.item;
      end else begin
        ent_nxt = prev_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

@@ hw/rtl/fftk_chain.sv @@
// ----------------------------------------------------------------------------
// fftk_chain: row of ranking cells
// Links the cells into a ring: each sees its upper neighbour for insertion and
// its lower neighbour for rotation. Exposes the head and tail entries.
// ----------------------------------------------------------------------------
module fftk_chain
  import fftk_pkg::*;
#(
  parameter int unsigned TOP_DEPTH = DEFAULT_TOP_DEPTH,
  parameter int unsigned CNT_W     = 6
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] count,
  output entry_t           head,
  output entry_t           tail
);

  entry_t ents  [TOP_DEPTH];
  logic   keeps [TOP_DEPTH];

  for (genvar i = 0; i < TOP_DEPTH; i++) begin : g_cell
    localparam int unsigned PREV = (i == 0) ? 0 : i - 1;
    localparam int unsigned NEXT = (i + 1) % TOP_DEPTH;

    fftk_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .prev_keep ((i == 0) ? 1'b1 : keeps[PREV]),
      .prev_ent  (ents[PREV]),
      .next_ent  (ents[NEXT]),
      .ent       (ents[i]),
      .keep      (keeps[i])
    );
  end

  assign head = ents[0];
  assign tail = ents[TOP_DEPTH-1];

endmodule

@@ hw/rtl/fragmented_file_top_k_tracker.sv @@
// The first result of a word appears in the cycle after it is taken.
// Record and clear words are taken every cycle while busy is low; busy stays
// low for them. A report gives its summary in the cycle after start, then,
// if the table holds entries, busy is high while the cell ring rotates once
// and the entries come out one per cycle. Results cannot be held off.
// Synchronous reset clears the counters and the entry count; no clearing pass.
// ----------------------------------------------------------------------------
// fragmented_file_top_k_tracker: top level
// Counts recorded files and keeps the TOP_DEPTH most fragmented ones in a
// sorted row of cells; reports counters and the ranked table on request.
// ----------------------------------------------------------------------------
module fragmented_file_top_k_tracker
  import fftk_pkg::*;
#(
  parameter int unsigned TOP_DEPTH = DEFAULT_TOP_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_operation,
  input  logic [TAG_W-1:0]     in_file_tag,
  input  logic [FRAG_W-1:0]    in_fragment_count,
  input  logic [SIZE_W-1:0]    in_file_size,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic [1:0]           out_status,
  output logic [FILES_W-1:0]   out_files_total,
  output logic [FILES_W-1:0]   out_fragmented_total,
  output logic [SUM_W-1:0]     out_fragments_total,
  output logic [TAG_W-1:0]     out_entry_tag,
  output logic [FRAG_W-1:0]    out_entry_fragments,
  output logic [SIZE_W-1:0]    out_entry_size,
  output logic                 out_last
);

  localparam int unsigned CNT_W = $clog2(TOP_DEPTH + 1);
  localparam int unsigned IDX_W = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]     rot_r, rot_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [FILES_W-1:0]   files_r, files_nxt;
  logic [FILES_W-1:0]   fragd_r, fragd_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [MINSIZE_W-1:0] min_size_r;
  logic [FILES_W-1:0]   max_files_r;

  logic                 valid_r, valid_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [FILES_W-1:0]   o_files_r, o_files_nxt;
  logic [FILES_W-1:0]   o_fragd_r, o_fragd_nxt;
  logic [SUM_W-1:0]     o_sum_r, o_sum_nxt;
  entry_t               o_ent_r, o_ent_nxt;
  logic                 last_r, last_nxt;

  logic                 accept;
  logic                 rotating;
  logic [FILES_W-1:0]   limit;
  logic [FRAG_W-1:0]    frag_eff;
  logic [SUM_W:0]       sum_wide;
  logic [CNT_W-1:0]     rot_ext;
  logic                 table_full;
  cell_ctl_t            ctl;
  entry_t               head;
  entry_t               tail;

  assign accept   = start && !busy;
  assign limit    = (max_files_r == '0) ? DEFAULT_MAX_FILES : max_files_r;
  assign frag_eff = (in_fragment_count == '0) ? FRAG_W'(1) : in_fragment_count;
  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(frag_eff);
  assign rot_ext  = CNT_W'(rot_r);
  assign table_full = (count_r == CNT_W'(TOP_DEPTH));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_REPORT) && (count_r != '0)) begin
          state_nxt = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (rot_r == IDX_W'(TOP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy     = 1'b0;
    rotating = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        rotating = 1'b0;
      end
      ST_ROTATE: begin
        busy     = 1'b1;
        rotating = 1'b1;
      end
      default: begin
        busy     = 1'b0;
        rotating = 1'b0;
      end
    endcase
  end

  // Counters, cell control and the result word.
  always_comb begin
    files_nxt   = files_r;
    fragd_nxt   = fragd_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    rot_nxt     = '0;
    ctl.ins     = 1'b0;
    ctl.rot     = rotating;
    ctl.item    = '{tag: in_file_tag, frag: frag_eff, size: in_file_size};
    valid_nxt   = 1'b0;
    kind_nxt    = KIND_ACK;
    status_nxt  = STATUS_COUNTED;
    o_files_nxt = '0;
    o_fragd_nxt = '0;
    o_sum_nxt   = '0;
    o_ent_nxt   = '0;
    last_nxt    = 1'b0;

    if (rotating) begin
      rot_nxt = (rot_r == IDX_W'(TOP_DEPTH - 1)) ? '0 : rot_r + IDX_W'(1);
      if (rot_ext < count_r) begin
        valid_nxt = 1'b1;
        kind_nxt  = KIND_ENTRY;
        o_ent_nxt = head;
        last_nxt  = (rot_ext + CNT_W'(1)) == count_r;
      end
    end else if (accept) begin
      case (in_operation)
        OP_RECORD: begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_ACK;
          last_nxt  = 1'b1;
          if (files_r >= limit) begin
            status_nxt = STATUS_LIMIT;
          end else if (in_file_size < SIZE_W'(min_size_r)) begin
            status_nxt = STATUS_SMALL;
          end else begin
            status_nxt = STATUS_COUNTED;
            files_nxt  = files_r + FILES_W'(1);
            sum_nxt    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            if (frag_eff > FRAG_W'(1)) begin
              fragd_nxt = fragd_r + FILES_W'(1);
              if (!table_full) begin
                ctl.ins   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else if (frag_eff > tail.frag) begin
                ctl.ins = 1'b1;
              end
            end
          end
          o_files_nxt = files_nxt;
          o_fragd_nxt = fragd_nxt;
          o_sum_nxt   = sum_nxt;
        end
        OP_REPORT: begin
          valid_nxt   = 1'b1;
          kind_nxt    = KIND_SUMMARY;
          o_files_nxt = files_r;
          o_fragd_nxt = fragd_r;
          o_sum_nxt   = sum_r;
          last_nxt    = (count_r == '0);
        end
        OP_CLEAR: begin
          files_nxt = '0;
          fragd_nxt = '0;
          sum_nxt   = '0;
          count_nxt = '0;
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= '0;
      count_r     <= '0;
      files_r     <= '0;
      fragd_r     <= '0;
      sum_r       <= '0;
      min_size_r  <= DEFAULT_MIN_SIZE;
      max_files_r <= DEFAULT_MAX_FILES;
      valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rot_r   <= rot_nxt;
      count_r <= count_nxt;
      files_r <= files_nxt;
      fragd_r <= fragd_nxt;
      sum_r   <= sum_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_FILE_SIZE: min_size_r  <= cfg_wdata;
          REG_MAX_FILES:     max_files_r <= cfg_wdata[FILES_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    status_r  <= status_nxt;
    o_files_r <= o_files_nxt;
    o_fragd_r <= o_fragd_nxt;
    o_sum_r   <= o_sum_nxt;
    o_ent_r   <= o_ent_nxt;
    last_r    <= last_nxt;
  end

  fftk_chain #(
    .TOP_DEPTH (TOP_DEPTH),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count_r),
    .head  (head),
    .tail  (tail)
  );

  assign out_valid            = valid_r;
  assign out_kind             = kind_r;
  assign out_status           = status_r;
  assign out_files_total      = o_files_r;
  assign out_fragmented_total = o_fragd_r;
  assign out_fragments_total  = o_sum_r;
  assign out_entry_tag        = o_ent_r.tag;
  assign out_entry_fragments  = o_ent_r.frag;
  assign out_entry_size       = o_ent_r.size;
  assign out_last             = last_r;

endmodule

@@ hw/rtl/fftk_checker.sv @@
// ----------------------------------------------------------------------------
// fftk_checker: port-level checks of the tracker
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module fftk_checker
  import fftk_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_operation,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // A taken record word is acknowledged in the next cycle with last set.
  a_record_ack : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_RECORD)
    |=> out_valid && (out_kind == KIND_ACK) && out_last)
    else $error("record word not acknowledged in the next cycle");

  // A taken report word gives its summary in the next cycle.
  a_report_summary : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_REPORT)
    |=> out_valid && (out_kind == KIND_SUMMARY))
    else $error("report word did not give a summary");

  // A clear word produces no result.
  a_clear_silent : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_CLEAR) |=> !out_valid)
    else $error("clear word produced a result");

  // Table entries only come out while a report is being read out.
  a_entry_in_report : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ENTRY) |-> $past(busy))
    else $error("table entry outside a report");

endmodule

bind fragmented_file_top_k_tracker fftk_checker u_fftk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_kind     (out_kind),
  .out_last     (out_last)
);
